FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the ducking block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/sdad_pkg.sv
package sdad_pkg;

   typedef logic [15:0] q15_type;
   typedef logic [31:0] ms_type;
   typedef logic [1:0]  csr_index_type;

   localparam int WHEEL_COUNT = 8;
   localparam int USED_WHEELS = (WHEEL_COUNT < 8) ? WHEEL_COUNT : 8;

   localparam logic [31:0] HOLDOFF_MS     = 32'd50;
   localparam logic [15:0] ONE_Q15        = 16'h8000;
   localparam logic [31:0] EXP_STEP_Q30   = 32'd1069455435;
   localparam logic [15:0] SEND_THRESHOLD = 16'd164;
   localparam logic [6:0]  MAX_STEP_MS    = 7'd100;
   localparam logic [19:0] AIR_OFFSET     = 20'd3200;
   localparam logic [19:0] AIR_SPAN       = 20'd60800;
   localparam logic [19:0] ROAD_OFFSET    = 20'd1280;
   localparam logic [19:0] ROAD_SPAN      = 20'd49920;
   localparam logic [17:0] TARGET_CLIP    = 18'd163840;
   localparam logic [3:0]  DIV_STEPS      = 4'd15;

   // reciprocals: ceil(2^33 / 475), ceil(2^33 / 195), ceil(2^20 / 5)
   localparam logic [31:0] AIR_RECIP      = 32'd18084073;
   localparam logic [31:0] ROAD_RECIP     = 32'd44050947;
   localparam logic [31:0] FIFTH_RECIP    = 32'd209716;

   localparam csr_index_type CSR_EFFECT_ENABLED = 2'd0;
   localparam csr_index_type CSR_INTERIOR_DEPTH = 2'd1;
   localparam csr_index_type CSR_EXTERIOR_DEPTH = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RATIO_WAIT,
      ST_CURVE,
      ST_CURVE_WAIT,
      ST_SQUARE,
      ST_CUBE,
      ST_SHAPE,
      ST_ROAD_SCALE,
      ST_ROAD_ROUND,
      ST_TARGET,
      ST_TARGET_WAIT,
      ST_GAIN,
      ST_GAIN_ROUND,
      ST_ALPHA,
      ST_ALPHA_ROUND,
      ST_APPROACH,
      ST_APPROACH_ROUND,
      ST_SEND,
      ST_RESPOND
   } state_type;

endpackage

FILE: hw/rtl/speed_driven_audio_ducking.sv
// Speed-driven media ducking. Each update word gives time, speed, wheel masks and the
// driving and camera flags; the block answers with one word holding the published Q1.15
// intensity, media gain and grounded ratio, plus a send request for the gain. One shared
// multiplier (registered product) forms every product, the constant divisions of the
// speed curves and of the target mix included as reciprocal products, and one shared
// bit-serial divider forms the grounded ratio, all under a sequencer; the block takes
// no new word until the answer has been taken. A reset request or a word skipped by the
// 50 ms holdoff goes straight to the answer; an update that restarts the smoothing skips
// the alpha power loop, and any other update runs that loop once per millisecond of
// time step (step capped at 100 ms). Configuration writes are always taken and belong
// in idle periods.
`include "assert_macros.svh"

module speed_driven_audio_ducking (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  sdad_pkg::ms_type       req_now_ms,
   input  logic signed [15:0]     req_speed,
   input  logic [7:0]             req_wheel_seen_mask,
   input  logic [7:0]             req_wheel_grounded_mask,
   input  logic                   req_driving,
   input  logic                   req_interior_view,
   input  logic                   req_send_accepted,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sdad_pkg::q15_type      rsp_intensity,
   output sdad_pkg::q15_type      rsp_media_gain,
   output sdad_pkg::q15_type      rsp_ground_share,
   output logic                   rsp_interior_flag,
   output logic                   rsp_updated,
   output logic                   rsp_send_valid,
   output sdad_pkg::q15_type      rsp_send_gain,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  sdad_pkg::csr_index_type csr_index,
   input  sdad_pkg::q15_type      csr_wdata
);
   import sdad_pkg::*;

   // sequencer and captured word
   state_type state_ff, state_in;
   logic        mode_ff, mode_in;
   ms_type      now_ff, now_in;
   logic [15:0] speed_ff, speed_in;
   logic [7:0]  seen_ff, seen_in;
   logic [7:0]  gnd_ff, gnd_in;
   logic        drv_ff, drv_in;
   logic        intv_ff, intv_in;
   logic        acc_ff, acc_in;

   // configuration
   logic        en_ff;
   q15_type     idepth_ff, edepth_ff;

   // architectural state
   ms_type      prev_tick_ff, prev_tick_in;
   q15_type     s_int_ff, s_int_in;
   q15_type     s_gain_ff, s_gain_in;
   q15_type     ls_gain_ff, ls_gain_in;
   logic        ls_valid_ff, ls_valid_in;
   ms_type      ls_time_ff, ls_time_in;
   logic        restart_ff, restart_in;
   q15_type     pub_int_ff, pub_int_in;
   q15_type     pub_gain_ff, pub_gain_in;
   q15_type     pub_ratio_ff, pub_ratio_in;
   logic        pub_intr_ff, pub_intr_in;
   logic        upd_ff, upd_in;
   logic        sv_ff, sv_in;
   q15_type     sg_ff, sg_in;

   // working registers
   logic        first_ff, first_in;
   logic [6:0]  d_ff, d_in;
   logic [6:0]  k_ff, k_in;
   q15_type     x_ff, x_in;
   logic        road_sel_ff, road_sel_in;
   q15_type     ratio_ff, ratio_in;
   q15_type     air_ff, air_in;
   q15_type     road_ff, road_in;
   q15_type     ti_ff, ti_in;
   q15_type     tg_ff, tg_in;
   logic [30:0] p_ff, p_in;
   q15_type     alpha_ff, alpha_in;
   logic        gain_sel_ff, gain_sel_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;

   // shared multiplier
   logic        mul_en;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;

   // shared divider: floor((num * 2^15 + low) / den), num < den
   logic        dv_start;
   logic [15:0] dv_num, dv_den;
   logic [14:0] dv_low;
   logic [15:0] dv_rem_ff, dv_rem_in;
   logic [14:0] dv_lowr_ff, dv_lowr_in;
   logic [14:0] dv_quo_ff, dv_quo_in;
   logic [3:0]  dv_cnt_ff, dv_cnt_in;
   logic [15:0] dv_den_ff, dv_den_in;
   logic [16:0] dv_shift;

   // combinational helpers
   logic [16:0] sext, abs_speed;
   logic [19:0] a9, c_off, c_span, c_num;
   logic [3:0]  seen_cnt, gnd_cnt;
   ms_type      delta, send_delta;
   logic        skip, first_now, moved, free_slot;
   logic [63:0] rnd29, rnd14;
   logic [16:0] w_fac;
   logic [17:0] t_num;
   q15_type     depth_sel, depth_sat;
   q15_type     ap_s, ap_t, gdiff;
   logic [16:0] ap_q;
   logic [17:0] ap_r;
   q15_type     ap_res;
   q15_type     tg_now;
   logic [30:0] p_one;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);
   assign csr_ready = 1'b1;
   assign rsp_intensity      = pub_int_ff;
   assign rsp_media_gain     = pub_gain_ff;
   assign rsp_ground_share   = pub_ratio_ff;
   assign rsp_interior_flag  = pub_intr_ff;
   assign rsp_updated        = upd_ff;
   assign rsp_send_valid     = sv_ff;
   assign rsp_send_gain      = sg_ff;

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   assign p_one = 31'h4000_0000;

   // count seen and grounded wheels
   always_comb begin
      seen_cnt = 4'd0;
      gnd_cnt  = 4'd0;
      for (int i = 0; i < USED_WHEELS; i++) begin
         if (seen_ff[i]) begin
            seen_cnt = seen_cnt + 4'd1;
            if (gnd_ff[i]) gnd_cnt = gnd_cnt + 4'd1;
         end
      end
   end

   // speed magnitude, curve operands and rounding sums
   always_comb begin
      sext      = {speed_ff[15], speed_ff};
      abs_speed = speed_ff[15] ? (~sext + 17'd1) : sext;
      a9        = {abs_speed, 3'b000} + {3'b000, abs_speed};
      c_off     = road_sel_ff ? ROAD_OFFSET : AIR_OFFSET;
      c_span    = road_sel_ff ? ROAD_SPAN : AIR_SPAN;
      c_num     = a9 - c_off;
      rnd29     = prod_ff + 64'h2000_0000;
      rnd14     = prod_ff + 64'h4000;
      w_fac     = 17'd98304 - {x_ff, 1'b0};
      t_num     = ({2'b00, air_ff} + {1'b0, air_ff, 1'b0}) + {1'b0, road_ff, 1'b0} + 18'd2;
      depth_sel = intv_ff ? idepth_ff : edepth_ff;
      depth_sat = (depth_sel > ONE_Q15) ? ONE_Q15 : depth_sel;
      tg_now    = ONE_Q15 - rnd14[30:15];
      delta     = now_ff - prev_tick_ff;
      send_delta = now_ff - ls_time_ff;
      skip      = !restart_ff && (prev_tick_ff != 32'd0) && (now_ff >= prev_tick_ff)
                  && (delta < HOLDOFF_MS);
      first_now = (prev_tick_ff == 32'd0) || (now_ff < prev_tick_ff) || restart_ff;
      ap_s      = gain_sel_ff ? s_gain_ff : s_int_ff;
      ap_t      = gain_sel_ff ? tg_ff : ti_ff;
      ap_q      = rnd14[31:15];
      ap_r      = neg_ff ? ({2'b00, ap_s} - {1'b0, ap_q}) : ({2'b00, ap_s} + {1'b0, ap_q});
      if (ap_r[17]) ap_res = 16'd0;
      else if (ap_r[16:0] > {1'b0, ONE_Q15}) ap_res = ONE_Q15;
      else ap_res = ap_r[15:0];
      gdiff     = (s_gain_ff >= ls_gain_ff) ? (s_gain_ff - ls_gain_ff)
                                            : (ls_gain_ff - s_gain_ff);
      moved     = !ls_valid_ff || (gdiff >= SEND_THRESHOLD);
      free_slot = (ls_time_ff == 32'd0) || (now_ff < ls_time_ff) || (send_delta >= HOLDOFF_MS);
   end

   // sequencer: next state, datapath loads, shared unit operands
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; now_in = now_ff; speed_in = speed_ff; seen_in = seen_ff;
      gnd_in = gnd_ff; drv_in = drv_ff; intv_in = intv_ff; acc_in = acc_ff;
      prev_tick_in = prev_tick_ff; s_int_in = s_int_ff; s_gain_in = s_gain_ff;
      ls_gain_in = ls_gain_ff; ls_valid_in = ls_valid_ff; ls_time_in = ls_time_ff;
      restart_in = restart_ff; pub_int_in = pub_int_ff; pub_gain_in = pub_gain_ff;
      pub_ratio_in = pub_ratio_ff; pub_intr_in = pub_intr_ff; upd_in = upd_ff;
      sv_in = sv_ff; sg_in = sg_ff;
      first_in = first_ff; d_in = d_ff; k_in = k_ff; x_in = x_ff;
      road_sel_in = road_sel_ff; ratio_in = ratio_ff; air_in = air_ff; road_in = road_ff;
      ti_in = ti_ff; tg_in = tg_ff; p_in = p_ff; alpha_in = alpha_ff;
      gain_sel_in = gain_sel_ff; neg_in = neg_ff;
      mul_en = 1'b0; mul_a = 32'd0; mul_b = 32'd0;
      dv_start = 1'b0; dv_num = 16'd0; dv_low = 15'd0; dv_den = 16'd0;

      case (state_ff)
         ST_IDLE: begin
            // hold a new word
            if (req_valid) begin
               mode_in = req_mode; now_in = req_now_ms; speed_in = req_speed;
               seen_in = req_wheel_seen_mask; gnd_in = req_wheel_grounded_mask;
               drv_in = req_driving; intv_in = req_interior_view;
               acc_in = req_send_accepted;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            upd_in = 1'b0; sv_in = 1'b0; sg_in = 16'd0;
            if (mode_ff) begin
               // republish unity gain and force a restart
               pub_int_in = 16'd0; pub_gain_in = ONE_Q15;
               sv_in = 1'b1; sg_in = ONE_Q15;
               if (acc_ff) begin
                  ls_gain_in = ONE_Q15; ls_valid_in = 1'b1;
               end
               restart_in = 1'b1;
               state_in = ST_RESPOND;
            end else if (skip) begin
               state_in = ST_RESPOND;
            end else begin
               first_in = first_now;
               d_in = first_now ? 7'd0
                    : ((delta > {25'd0, MAX_STEP_MS}) ? MAX_STEP_MS : delta[6:0]);
               restart_in = 1'b0;
               prev_tick_in = now_ff;
               road_sel_in = 1'b0;
               if (seen_cnt == 4'd0 || gnd_cnt == seen_cnt) begin
                  ratio_in = ONE_Q15;
                  state_in = ST_CURVE;
               end else begin
                  dv_start = 1'b1;
                  dv_num = {12'd0, gnd_cnt};
                  dv_low = {12'd0, seen_cnt[3:1]};
                  dv_den = {12'd0, seen_cnt};
                  state_in = ST_RATIO_WAIT;
               end
            end
         end
         ST_RATIO_WAIT: begin
            if (dv_cnt_ff == 4'd0) begin
               ratio_in = {1'b0, dv_quo_ff};
               state_in = ST_CURVE;
            end
         end
         ST_CURVE: begin
            // clamp ends, scale the middle by 2^15 / span as a reciprocal product
            if (a9 <= c_off) begin
               x_in = 16'd0;
               state_in = ST_SQUARE;
            end else if (c_num >= c_span) begin
               x_in = ONE_Q15;
               state_in = ST_SQUARE;
            end else begin
               mul_en = 1'b1;
               mul_a = road_sel_ff ? {9'd0, c_num[15:0], 7'd0} : {8'd0, c_num[15:0], 8'd0};
               mul_b = road_sel_ff ? ROAD_RECIP : AIR_RECIP;
               state_in = ST_CURVE_WAIT;
            end
         end
         ST_CURVE_WAIT: begin
            x_in = {1'b0, prod_ff[47:33]};
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            mul_en = 1'b1; mul_a = {16'd0, x_ff}; mul_b = {16'd0, x_ff};
            state_in = ST_CUBE;
         end
         ST_CUBE: begin
            mul_en = 1'b1; mul_a = prod_ff[31:0]; mul_b = {15'd0, w_fac};
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            if (road_sel_ff) begin
               road_in = rnd29[45:30];
               state_in = ST_ROAD_SCALE;
            end else begin
               air_in = rnd29[45:30];
               road_sel_in = 1'b1;
               state_in = ST_CURVE;
            end
         end
         ST_ROAD_SCALE: begin
            mul_en = 1'b1; mul_a = {16'd0, road_ff}; mul_b = {16'd0, ratio_ff};
            state_in = ST_ROAD_ROUND;
         end
         ST_ROAD_ROUND: begin
            road_in = rnd14[30:15];
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            // zero when off or not driving, clip at the top, else divide the mix by five as a reciprocal product
            if (!(en_ff && drv_ff)) begin
               ti_in = 16'd0;
               state_in = ST_GAIN;
            end else if (t_num >= TARGET_CLIP) begin
               ti_in = ONE_Q15;
               state_in = ST_GAIN;
            end else begin
               mul_en = 1'b1; mul_a = {14'd0, t_num}; mul_b = FIFTH_RECIP;
               state_in = ST_TARGET_WAIT;
            end
         end
         ST_TARGET_WAIT: begin
            ti_in = {1'b0, prod_ff[34:20]};
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_en = 1'b1; mul_a = {16'd0, ti_ff}; mul_b = {16'd0, depth_sat};
            state_in = ST_GAIN_ROUND;
         end
         ST_GAIN_ROUND: begin
            tg_in = tg_now;
            if (first_ff) begin
               s_int_in = ti_ff;
               s_gain_in = tg_now;
               state_in = ST_SEND;
            end else begin
               p_in = p_one;
               k_in = 7'd0;
               state_in = ST_ALPHA;
            end
         end
         ST_ALPHA: begin
            // advance the decay power one millisecond at a time
            if (k_ff == d_ff) begin
               alpha_in = 16'((({1'b0, p_one} - {1'b0, p_ff}) + 32'h4000) >> 15);
               gain_sel_in = 1'b0;
               state_in = ST_APPROACH;
            end else begin
               mul_en = 1'b1; mul_a = {1'b0, p_ff}; mul_b = EXP_STEP_Q30;
               state_in = ST_ALPHA_ROUND;
            end
         end
         ST_ALPHA_ROUND: begin
            p_in = rnd29[60:30];
            k_in = k_ff + 7'd1;
            state_in = ST_ALPHA;
         end
         ST_APPROACH: begin
            neg_in = (ap_t < ap_s);
            mul_en = 1'b1;
            mul_a = {16'd0, (ap_t < ap_s) ? (ap_s - ap_t) : (ap_t - ap_s)};
            mul_b = {16'd0, alpha_ff};
            state_in = ST_APPROACH_ROUND;
         end
         ST_APPROACH_ROUND: begin
            if (gain_sel_ff) begin
               s_gain_in = ap_res;
               state_in = ST_SEND;
            end else begin
               s_int_in = ap_res;
               gain_sel_in = 1'b1;
               state_in = ST_APPROACH;
            end
         end
         ST_SEND: begin
            // publish and raise a throttled send
            pub_ratio_in = ratio_ff; pub_int_in = s_int_ff; pub_gain_in = s_gain_ff;
            pub_intr_in = intv_ff; upd_in = 1'b1;
            if (moved && free_slot) begin
               ls_time_in = now_ff;
               sv_in = 1'b1;
               sg_in = s_gain_ff;
               if (acc_ff) begin
                  ls_gain_in = s_gain_ff; ls_valid_in = 1'b1;
               end
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      prod_in = mul_en ? mul_p : prod_ff;
   end

   // shared divider, one quotient bit a cycle
   always_comb begin
      dv_rem_in = dv_rem_ff; dv_lowr_in = dv_lowr_ff; dv_quo_in = dv_quo_ff;
      dv_cnt_in = dv_cnt_ff; dv_den_in = dv_den_ff;
      dv_shift = {dv_rem_ff, dv_lowr_ff[14]};
      if (dv_start) begin
         dv_rem_in = dv_num; dv_lowr_in = dv_low; dv_den_in = dv_den;
         dv_quo_in = 15'd0; dv_cnt_in = DIV_STEPS;
      end else if (dv_cnt_ff != 4'd0) begin
         if (dv_shift >= {1'b0, dv_den_ff}) begin
            dv_rem_in = 16'(dv_shift - {1'b0, dv_den_ff});
            dv_quo_in = {dv_quo_ff[13:0], 1'b1};
         end else begin
            dv_rem_in = dv_shift[15:0];
            dv_quo_in = {dv_quo_ff[13:0], 1'b0};
         end
         dv_lowr_in = {dv_lowr_ff[13:0], 1'b0};
         dv_cnt_in = dv_cnt_ff - 4'd1;
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dv_cnt_ff <= 4'd0;
         en_ff <= 1'b1; idepth_ff <= 16'd0; edepth_ff <= 16'd0;
         prev_tick_ff <= 32'd0; s_int_ff <= 16'd0; s_gain_ff <= ONE_Q15;
         ls_gain_ff <= 16'd0; ls_valid_ff <= 1'b0; ls_time_ff <= 32'd0;
         restart_ff <= 1'b0; pub_int_ff <= 16'd0; pub_gain_ff <= ONE_Q15;
         pub_ratio_ff <= 16'd0; pub_intr_ff <= 1'b0; upd_ff <= 1'b0;
         sv_ff <= 1'b0; sg_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         dv_cnt_ff <= dv_cnt_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_EFFECT_ENABLED: en_ff <= csr_wdata[0];
               CSR_INTERIOR_DEPTH: idepth_ff <= csr_wdata;
               CSR_EXTERIOR_DEPTH: edepth_ff <= csr_wdata;
               default: ;
            endcase
         end
         prev_tick_ff <= prev_tick_in; s_int_ff <= s_int_in; s_gain_ff <= s_gain_in;
         ls_gain_ff <= ls_gain_in; ls_valid_ff <= ls_valid_in; ls_time_ff <= ls_time_in;
         restart_ff <= restart_in; pub_int_ff <= pub_int_in; pub_gain_ff <= pub_gain_in;
         pub_ratio_ff <= pub_ratio_in; pub_intr_ff <= pub_intr_in; upd_ff <= upd_in;
         sv_ff <= sv_in; sg_ff <= sg_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in; now_ff <= now_in; speed_ff <= speed_in; seen_ff <= seen_in;
      gnd_ff <= gnd_in; drv_ff <= drv_in; intv_ff <= intv_in; acc_ff <= acc_in;
      first_ff <= first_in; d_ff <= d_in; k_ff <= k_in; x_ff <= x_in;
      road_sel_ff <= road_sel_in; ratio_ff <= ratio_in; air_ff <= air_in;
      road_ff <= road_in; ti_ff <= ti_in; tg_ff <= tg_in; p_ff <= p_in;
      alpha_ff <= alpha_in; gain_sel_ff <= gain_sel_in; neg_ff <= neg_in;
      prod_ff <= prod_in;
      dv_rem_ff <= dv_rem_in; dv_lowr_ff <= dv_lowr_in; dv_quo_ff <= dv_quo_in;
      dv_den_ff <= dv_den_in;
   end

   `ASSERT_IMPLIES(a_no_take_while_answering, clock, reset, rsp_valid, !req_ready)
   `ASSERT_IMPLIES(a_div_only_when_waiting, clock, reset, dv_cnt_ff != 4'd0, state_ff == ST_RATIO_WAIT)
   `ASSERT_IMPLIES(a_gain_in_range, clock, reset, rsp_valid, rsp_media_gain <= ONE_Q15 && rsp_intensity <= ONE_Q15)
   `ASSERT_IMPLIES(a_reset_send_unity, clock, reset, rsp_valid && rsp_send_valid && !rsp_updated, rsp_send_gain == ONE_Q15)
   `ASSERT_NEXT(a_alpha_steps_bounded, clock, reset, state_ff == ST_ALPHA_ROUND, k_ff <= MAX_STEP_MS)

endmodule
